[rtl/radial_shading_pattern_defines.svh]
// assertion macros shared by the front end and search cell modules
`ifndef RADIAL_SHADING_PATTERN_DEFINES_SVH
`define RADIAL_SHADING_PATTERN_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define RSP_CHECK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next
`define RSP_CHECK_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rsp_pkg.sv]
// types and constants of the radial shading pattern block
package rsp_pkg;

	localparam int unsigned SIDE_W  = 13;
	localparam int unsigned COORD_W = 12;
	localparam int unsigned SQ_W    = 2 * COORD_W;
	localparam int unsigned SUM_W   = SQ_W + 1;
	localparam int unsigned TGT_W   = 42;
	localparam int unsigned JM_W    = SUM_W + 8;
	localparam int unsigned K_W     = 8;
	localparam int unsigned VAL_W   = 8;

	// sides above this are clamped
	localparam logic [16:0] MAX_SIDE = 17'd4096;
	// 255 squared
	localparam logic [15:0] SCALE_SQ = 16'd65025;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	// search state handed from cell to cell
	typedef struct packed {
		logic [TGT_W-1:0] tgt;  // 65025 * d
		logic [SUM_W-1:0] m;    // cx^2 + cy^2
		logic [TGT_W-1:0] s;    // j^2 * m
		logic [JM_W-1:0]  jm;   // j * m
		logic [K_W-1:0]   j;    // largest j with j^2 * m < tgt, bits so far
		logic             full; // center pixel or degenerate image
	} srch_t;

endpackage

[rtl/radial_shading_pattern.sv]
// top level of the radial shading pattern generator
// Radial shading pattern: for each (pixel_x, pixel_y) transfer the block returns one 8-bit
// pixel_value that is 255 at the image center (width/2, height/2) and falls linearly with
// Euclidean distance to 0 at the distance of corner (0,0), saturating to 0 beyond it. With
// d = dx^2 + dy^2 and m = cx^2 + cy^2, the value is 255 - k for the least k with
// k^2 * m >= 65025 * d; a degenerate image (m = 0) gives 255 everywhere, and sides above
// MAX_SIDE are clamped. The datapath is fully pipelined: one new pixel can be taken every
// clock while the output is not stalled, and each result passes through three front stages
// for squares and the scaled target, eight search cells that settle one bit of the ratio
// each, and one output register. Stalls on the output side back-pressure stage by stage,
// so bubbles are squeezed out before in_ready drops.
// image_width (index 0, reset 640) and image_height (index 1, reset 480) are written via
// cfg_we/cfg_idx/cfg_wdata by the user only while no pixel is in flight (not enforced).

module radial_shading_pattern (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_idx,
	input  logic [rsp_pkg::SIDE_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rsp_pkg::COORD_W-1:0]   pixel_x,
	input  logic [rsp_pkg::COORD_W-1:0]   pixel_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rsp_pkg::VAL_W-1:0]     pixel_value
);

	localparam int unsigned NCELL = rsp_pkg::K_W;

	// configuration registers
	logic [rsp_pkg::SIDE_W-1:0] width_q, height_q;

	// search chain links, entry 0 comes from the front end
	rsp_pkg::srch_t chain [0:NCELL];
	logic           vld   [0:NCELL];
	logic           rdy   [0:NCELL];

	// output register
	logic                       out_valid_q;
	logic [rsp_pkg::VAL_W-1:0]  value_q;
	logic [rsp_pkg::VAL_W-1:0]  value_nxt;
	rsp_pkg::srch_t             last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rsp_pkg::SIDE_W'(640);
			height_q <= rsp_pkg::SIDE_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				rsp_pkg::REG_WIDTH:  width_q  <= cfg_wdata;
				rsp_pkg::REG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// distances, squares and target over three stages
	rsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.width    (width_q),
		.height   (height_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.dn_valid (vld[0]),
		.dn_ready (rdy[0]),
		.dn_data  (chain[0])
	);

	// one cell per bit of j, most significant first
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		rsp_cell #(
			.BIT (NCELL - 1 - i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[i]),
			.up_ready (rdy[i]),
			.up_data  (chain[i]),
			.dn_valid (vld[i+1]),
			.dn_ready (rdy[i+1]),
			.dn_data  (chain[i+1])
		);
	end

	// j is the largest value with j^2 m below target, so k = j + 1;
	// k of 255 or more means at or past the corner distance
	assign last = chain[NCELL];
	always_comb begin
		if (last.full) begin
			value_nxt = '1;
		end else if (last.j >= rsp_pkg::K_W'(254)) begin
			value_nxt = '0;
		end else begin
			value_nxt = rsp_pkg::VAL_W'(254) - last.j;
		end
	end

	assign rdy[NCELL] = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy[NCELL]) begin
			out_valid_q <= vld[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NCELL]) value_q <= value_nxt;
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = value_q;

endmodule

[rtl/rsp_front.sv]
// front end: distances, squares and the scaled target
`include "radial_shading_pattern_defines.svh"

module rsp_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [rsp_pkg::SIDE_W-1:0]        width,
	input  logic [rsp_pkg::SIDE_W-1:0]        height,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rsp_pkg::COORD_W-1:0]       pixel_x,
	input  logic [rsp_pkg::COORD_W-1:0]       pixel_y,
	output logic                              dn_valid,
	input  logic                              dn_ready,
	output rsp_pkg::srch_t                    dn_data
);

	logic [rsp_pkg::SIDE_W-1:0]  sat_w, sat_h;
	logic [rsp_pkg::COORD_W-1:0] cx, cy, dx, dy;
	logic                        v_s1, v_s2, v_s3;
	logic                        rdy1, rdy2, rdy3;
	logic [rsp_pkg::SQ_W-1:0]    dx2_s1, dy2_s1, cx2_s1, cy2_s1;
	logic [rsp_pkg::SUM_W-1:0]   d_s2, m_s2, m_s3;
	logic [rsp_pkg::TGT_W-1:0]   tgt_s3;
	logic                        full_s3;

	// clamp to the largest side
	assign sat_w = ({4'd0, width} > rsp_pkg::MAX_SIDE) ?
		rsp_pkg::SIDE_W'(rsp_pkg::MAX_SIDE) : width;
	assign sat_h = ({4'd0, height} > rsp_pkg::MAX_SIDE) ?
		rsp_pkg::SIDE_W'(rsp_pkg::MAX_SIDE) : height;
	assign cx = sat_w[rsp_pkg::SIDE_W-1:1];
	assign cy = sat_h[rsp_pkg::SIDE_W-1:1];
	assign dx = (cx >= pixel_x) ? (cx - pixel_x) : (pixel_x - cx);
	assign dy = (cy >= pixel_y) ? (cy - pixel_y) : (pixel_y - cy);

	assign rdy3     = !v_s3 || dn_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			dx2_s1 <= rsp_pkg::SQ_W'(dx) * rsp_pkg::SQ_W'(dx);
			dy2_s1 <= rsp_pkg::SQ_W'(dy) * rsp_pkg::SQ_W'(dy);
			cx2_s1 <= rsp_pkg::SQ_W'(cx) * rsp_pkg::SQ_W'(cx);
			cy2_s1 <= rsp_pkg::SQ_W'(cy) * rsp_pkg::SQ_W'(cy);
		end
		if (rdy2) begin
			d_s2 <= rsp_pkg::SUM_W'(dx2_s1) + rsp_pkg::SUM_W'(dy2_s1);
			m_s2 <= rsp_pkg::SUM_W'(cx2_s1) + rsp_pkg::SUM_W'(cy2_s1);
		end
		if (rdy3) begin
			tgt_s3  <= rsp_pkg::TGT_W'(d_s2) * rsp_pkg::TGT_W'(rsp_pkg::SCALE_SQ);
			m_s3    <= m_s2;
			full_s3 <= (d_s2 == '0) || (m_s2 == '0);
		end
	end

	assign dn_valid     = v_s3;
	assign dn_data.tgt  = tgt_s3;
	assign dn_data.m    = m_s3;
	assign dn_data.s    = '0;
	assign dn_data.jm   = '0;
	assign dn_data.j    = '0;
	assign dn_data.full = full_s3;

	// a nonzero target can only be flagged when the image is degenerate
	`RSP_CHECK(a_full_cause, !(v_s3 && full_s3 && tgt_s3 != '0) || m_s3 == '0, "full flag without cause")

endmodule

[rtl/rsp_cell.sv]
// one search cell: settles one bit of the distance ratio
`include "radial_shading_pattern_defines.svh"

module rsp_cell #(
	parameter int unsigned BIT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  rsp_pkg::srch_t up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output rsp_pkg::srch_t dn_data
);

	localparam logic [rsp_pkg::K_W-1:0] BIT_MASK  = rsp_pkg::K_W'(1) << BIT;
	localparam logic [rsp_pkg::K_W-1:0] LOW_MASK  = BIT_MASK - rsp_pkg::K_W'(1);

	logic                        v_q;
	rsp_pkg::srch_t              st_q, nxt;
	logic [rsp_pkg::TGT_W-1:0]   cand;
	logic                        take;

	// (j + 2^b)^2 m = j^2 m + 2^(b+1) j m + 4^b m
	assign cand = up_data.s
		+ (rsp_pkg::TGT_W'(up_data.jm) << (BIT + 1))
		+ (rsp_pkg::TGT_W'(up_data.m) << (2 * BIT));
	assign take = cand < up_data.tgt;

	always_comb begin
		nxt = up_data;
		if (take) begin
			nxt.s  = cand;
			nxt.jm = up_data.jm + (rsp_pkg::JM_W'(up_data.m) << BIT);
			nxt.j  = up_data.j | BIT_MASK;
		end
	end

	assign up_ready = !v_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) st_q <= nxt;
	end

	assign dn_valid = v_q;
	assign dn_data  = st_q;

	`RSP_CHECK(a_low_bits_clear, !v_q || (st_q.j & LOW_MASK) == '0, "lower bits decided early")
	`RSP_CHECK(a_below_target, !v_q || st_q.j == '0 || st_q.s < st_q.tgt, "accepted step overshoots")
	`RSP_CHECK_NEXT(a_hold_on_stall, v_q && !dn_ready, v_q && $stable(st_q.j) && $stable(st_q.s), "cell lost data on stall")

endmodule
